// ===== rtl/srmve_pkg.sv =====
`timescale 1ns / 1ps

package srmve_pkg;

	localparam int POS_W = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TOTAL = 2'd1;

	localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
	localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

	typedef enum logic [2:0] {
		OP_SET_ROW     = 3'd0,
		OP_WRITE_ENTRY = 3'd1,
		OP_WRITE_X     = 3'd2,
		OP_WRITE_SUM   = 3'd3,
		OP_PRODUCT     = 3'd4,
		OP_TRANSPOSE   = 3'd5,
		OP_LOOKUP      = 3'd6,
		OP_SCALE       = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_ROW_RD,
		ST_ROW_WT,
		ST_ENT_RD,
		ST_ENT_WT,
		ST_OPND_WT,
		ST_ACC,
		ST_OUT_RD,
		ST_OUT_WT,
		ST_EMIT,
		ST_SC_RD,
		ST_SC_WT,
		ST_SC_WR
	} st_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [5:0]         row_index;
		logic [5:0]         column_index;
		logic [9:0]         entry_index;
		logic [10:0]        entry_count;
		logic signed [31:0] operand_value;
		logic               accumulate;
	} item_t;

	typedef struct packed {
		logic [5:0]         result_index;
		logic signed [31:0] result_value;
		logic               found;
		logic               last;
	} result_t;

	typedef struct packed {
		op_t                op;
		logic [5:0]         row;
		logic [5:0]         col;
		logic [9:0]         pos;
		logic [10:0]        cnt;
		logic signed [31:0] operand;
		logic               accumulate;
		logic               store_ok;
	} cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/srmve_front.sv =====
`timescale 1ns / 1ps

module srmve_front #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  srmve_pkg::item_t item,
	output logic             cmd_valid,
	input  logic             cmd_pop,
	output srmve_pkg::cmd_t  cmd
);
	import srmve_pkg::*;

	cmd_t       cls;
	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	always_comb begin
		cls.op = op_t'(item.opcode);
		cls.row = item.row_index;
		cls.col = item.column_index;
		cls.pos = item.entry_index;
		cls.cnt = item.entry_count;
		cls.operand = item.operand_value;
		cls.accumulate = item.accumulate;
		unique case (cls.op) inside
			OP_SET_ROW, OP_WRITE_X, OP_WRITE_SUM: begin
				cls.store_ok = {1'b0, item.row_index} < 7'(MAX_ROWS);
			end
			OP_WRITE_ENTRY: begin
				cls.store_ok = POS_W'(item.entry_index) < POS_W'(MAX_ENTRIES);
			end
			default: begin
				cls.store_ok = 1'b0;
			end
		endcase
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push = item_valid && !item_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_pop && cmd_valid;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/srmve_back.sv =====
`timescale 1ns / 1ps

module srmve_back #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  srmve_pkg::cmd_t    cmd,
	input  logic [6:0]         dim,
	input  logic [10:0]        scale_n,
	output logic               result_valid,
	input  logic               result_stall,
	output srmve_pkg::result_t result
);
	import srmve_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int EW = $clog2(MAX_ENTRIES);

	logic [9:0]         row_start_mem [MAX_ROWS];
	logic [10:0]        row_len_mem [MAX_ROWS];
	logic               len_vld_q [MAX_ROWS];
	logic [5:0]         col_mem [MAX_ENTRIES];
	logic signed [31:0] val_mem [MAX_ENTRIES];
	logic signed [31:0] x_mem [MAX_ROWS];
	logic signed [31:0] sum_mem [MAX_ROWS];

	logic [9:0]         rs_rd_q;
	logic [10:0]        rl_rd_q;
	logic               lv_rd_q;
	logic [5:0]         col_rd_q;
	logic signed [31:0] val_rd_q;
	logic signed [31:0] x_rd_q;
	logic signed [31:0] sum_rd_q;

	logic [RW-1:0]      row_ra;
	logic [RW-1:0]      row_wa;
	logic               row_we;
	logic [EW-1:0]      ent_ra;
	logic [EW-1:0]      ent_wa;
	logic               col_we;
	logic               val_we;
	logic signed [31:0] val_wd;
	logic [RW-1:0]      x_ra;
	logic               x_we;
	logic [RW-1:0]      sum_ra;
	logic [RW-1:0]      sum_wa;
	logic               sum_we;
	logic signed [31:0] sum_wd;

	st_t                state_q;
	st_t                state_d;
	cmd_t               cur_q;
	logic [6:0]         r_q;
	logic [10:0]        k_q;
	logic [9:0]         start_q;
	logic [10:0]        len_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] xr_q;
	logic [5:0]         col_q;
	logic signed [31:0] val_q;
	logic signed [31:0] opnd_q;
	logic signed [63:0] prod_q;
	logic [5:0]         em_idx_q;
	logic signed [31:0] em_val_q;
	logic               em_found_q;
	logic               em_last_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               em_load;
	logic [5:0]         em_idx_d;
	logic signed [31:0] em_val_d;
	logic               em_found_d;
	logic               em_last_d;

	logic [POS_W-1:0]   pos;
	logic [POS_W-1:0]   cmd_pos;
	logic               row_end;
	logic               last_row;
	logic               lk_stop;
	logic               lk_eq;
	logic               col_out;
	logic               slot_free;
	logic               sc_last;
	logic               is_tr;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [31:0] base;
	logic signed [48:0] sum49;
	logic signed [31:0] nv;

	assign pos = POS_W'(start_q) + POS_W'(k_q);
	assign cmd_pos = POS_W'(cmd.pos);
	assign row_end = (k_q >= len_q) || (pos >= POS_W'(MAX_ENTRIES));
	assign last_row = (r_q + 7'd1) == dim;
	assign lk_stop = col_rd_q >= cur_q.col;
	assign lk_eq = col_rd_q == cur_q.col;
	assign col_out = {1'b0, col_rd_q} >= dim;
	assign slot_free = !out_valid_q || !result_stall;
	assign sc_last = (k_q + 11'd1) == scale_n;
	assign is_tr = cur_q.op == OP_TRANSPOSE;

	assign mul_a = (state_q == ST_SC_WT) ? val_rd_q : val_q;
	assign mul_b = (state_q == ST_SC_WT) ? cur_q.operand : (is_tr ? xr_q : x_rd_q);
	assign base = (state_q == ST_SC_WR) ? 32'sd0 : (is_tr ? opnd_q : acc_q);
	assign sum49 = 49'(base) + 49'($signed(prod_q[63:16]));
	assign nv = sat32(sum49);

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		row_ra = r_q[RW-1:0];
		row_wa = cmd.row[RW-1:0];
		row_we = 1'b0;
		ent_ra = pos[EW-1:0];
		ent_wa = cmd_pos[EW-1:0];
		col_we = 1'b0;
		val_we = 1'b0;
		val_wd = cmd.operand;
		x_ra = r_q[RW-1:0];
		x_we = 1'b0;
		sum_ra = r_q[RW-1:0];
		sum_wa = r_q[RW-1:0];
		sum_we = 1'b0;
		sum_wd = cmd.operand;
		em_load = 1'b0;
		em_idx_d = cur_q.col;
		em_val_d = 32'sd0;
		em_found_d = 1'b0;
		em_last_d = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_SET_ROW: begin
							row_we = cmd.store_ok;
						end
						OP_WRITE_ENTRY: begin
							col_we = cmd.store_ok;
							val_we = cmd.store_ok;
						end
						OP_WRITE_X: begin
							x_we = cmd.store_ok;
						end
						OP_WRITE_SUM: begin
							sum_wa = cmd.row[RW-1:0];
							sum_we = cmd.store_ok;
						end
						OP_PRODUCT: begin
							if (dim != 7'd0) begin
								state_d = ST_ROW_RD;
							end
						end
						OP_TRANSPOSE: begin
							if (dim != 7'd0) begin
								state_d = ST_CLR;
							end
						end
						OP_LOOKUP: begin
							if ({1'b0, cmd.row} < dim && {1'b0, cmd.col} < dim) begin
								state_d = ST_ROW_RD;
							end else begin
								em_load = 1'b1;
								em_idx_d = cmd.col;
								state_d = ST_EMIT;
							end
						end
						OP_SCALE: begin
							if (scale_n != 11'd0) begin
								state_d = ST_SC_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CLR: begin
				sum_we = 1'b1;
				sum_wd = 32'sd0;
				if (last_row) begin
					state_d = ST_ROW_RD;
				end
			end
			ST_ROW_RD: begin
				if (cur_q.op == OP_LOOKUP) begin
					row_ra = cur_q.row[RW-1:0];
				end
				state_d = ST_ROW_WT;
			end
			ST_ROW_WT: begin
				state_d = ST_ENT_RD;
			end
			ST_ENT_RD: begin
				if (row_end) begin
					if (cur_q.op == OP_PRODUCT) begin
						sum_we = 1'b1;
						sum_wd = acc_q;
						em_load = 1'b1;
						em_idx_d = r_q[5:0];
						em_val_d = acc_q;
						em_found_d = 1'b1;
						em_last_d = last_row;
						state_d = ST_EMIT;
					end else if (is_tr) begin
						state_d = last_row ? ST_OUT_RD : ST_ROW_RD;
					end else begin
						em_load = 1'b1;
						state_d = ST_EMIT;
					end
				end else begin
					state_d = ST_ENT_WT;
				end
			end
			ST_ENT_WT: begin
				x_ra = col_rd_q[RW-1:0];
				sum_ra = col_rd_q[RW-1:0];
				if (cur_q.op == OP_LOOKUP) begin
					if (lk_stop) begin
						em_load = 1'b1;
						em_val_d = lk_eq ? val_rd_q : 32'sd0;
						em_found_d = lk_eq;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_ENT_RD;
					end
				end else if (col_out) begin
					state_d = ST_ENT_RD;
				end else begin
					state_d = ST_OPND_WT;
				end
			end
			ST_OPND_WT: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (is_tr) begin
					sum_wa = col_q[RW-1:0];
					sum_we = 1'b1;
					sum_wd = nv;
				end
				state_d = ST_ENT_RD;
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_WT;
			end
			ST_OUT_WT: begin
				em_load = 1'b1;
				em_idx_d = r_q[5:0];
				em_val_d = sum_rd_q;
				em_found_d = 1'b1;
				em_last_d = last_row;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					if (em_last_q) begin
						state_d = ST_IDLE;
					end else begin
						state_d = is_tr ? ST_OUT_RD : ST_ROW_RD;
					end
				end
			end
			ST_SC_RD: begin
				ent_ra = EW'(k_q);
				state_d = ST_SC_WT;
			end
			ST_SC_WT: begin
				state_d = ST_SC_WR;
			end
			ST_SC_WR: begin
				ent_wa = EW'(k_q);
				val_we = 1'b1;
				val_wd = nv;
				state_d = sc_last ? ST_IDLE : ST_SC_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_start_mem[row_wa] <= cmd.pos;
			row_len_mem[row_wa] <= cmd.cnt;
		end
		rs_rd_q <= row_start_mem[row_ra];
		rl_rd_q <= row_len_mem[row_ra];
		lv_rd_q <= len_vld_q[row_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ROWS; i++) begin
				len_vld_q[i] <= 1'b0;
			end
		end else if (row_we) begin
			len_vld_q[row_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[ent_wa] <= cmd.col;
		end
		col_rd_q <= col_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[ent_wa] <= val_wd;
		end
		val_rd_q <= val_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[row_wa] <= cmd.operand;
		end
		x_rd_q <= x_mem[x_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		sum_rd_q <= sum_mem[sum_ra];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cur_q <= cmd;
					r_q <= 7'd0;
					k_q <= 11'd0;
				end
			end
			ST_CLR: begin
				r_q <= last_row ? 7'd0 : r_q + 7'd1;
			end
			ST_ROW_WT: begin
				start_q <= rs_rd_q;
				len_q <= lv_rd_q ? rl_rd_q : 11'd0;
				k_q <= 11'd0;
				acc_q <= (cur_q.op == OP_PRODUCT && cur_q.accumulate) ? sum_rd_q : 32'sd0;
				xr_q <= x_rd_q;
			end
			ST_ENT_RD: begin
				if (row_end && is_tr) begin
					r_q <= last_row ? 7'd0 : r_q + 7'd1;
				end
			end
			ST_ENT_WT: begin
				col_q <= col_rd_q;
				val_q <= val_rd_q;
				if ((cur_q.op == OP_LOOKUP && !lk_stop) || (cur_q.op != OP_LOOKUP && col_out)) begin
					k_q <= k_q + 11'd1;
				end
			end
			ST_OPND_WT: begin
				prod_q <= mul_a * mul_b;
				opnd_q <= sum_rd_q;
			end
			ST_ACC: begin
				if (!is_tr) begin
					acc_q <= nv;
				end
				k_q <= k_q + 11'd1;
			end
			ST_EMIT: begin
				if (slot_free && !em_last_q) begin
					r_q <= r_q + 7'd1;
				end
			end
			ST_SC_WT: begin
				prod_q <= mul_a * mul_b;
			end
			ST_SC_WR: begin
				k_q <= k_q + 11'd1;
			end
			default: begin
			end
		endcase
		if (em_load) begin
			em_idx_q <= em_idx_d;
			em_val_q <= em_val_d;
			em_found_q <= em_found_d;
			em_last_q <= em_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			out_q.result_index <= em_idx_q;
			out_q.result_value <= em_val_q;
			out_q.found <= em_found_q;
			out_q.last <= em_last_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// ===== rtl/sparse_row_matrix_vector_engine_unit.sv =====
`timescale 1ns / 1ps

// Sparse matrix-vector engine holding a row-compressed matrix, an x vector and a sum
// vector. Transactions enter a two-deep queue and are executed by a sequencer that owns
// the stores; each store has one read and one write port. A product walks each row's
// stored entries through the single multiplier and the registered store reads and
// emits a result per row; out-of-range columns skip the multiply. A transpose product
// first clears the sums and afterwards reads them out. A lookup walks the row's entries
// and a scale rewrites each stored entry in turn. Row lengths read as zero until
// written, so no clearing pass follows reset.
module sparse_row_matrix_vector_engine_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  srmve_pkg::item_t                      item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output srmve_pkg::result_t                    result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [srmve_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [10:0]                           cfg_data
);
	import srmve_pkg::*;

	logic [6:0]       dimension_q;
	logic [10:0]      entry_total_q;
	logic [6:0]       dim_used;
	logic [10:0]      scale_n;
	logic             cmd_valid;
	logic             cmd_pop;
	cmd_t             cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q <= 7'd1;
			entry_total_q <= 11'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIMENSION: dimension_q <= cfg_data[6:0];
				REG_ENTRY_TOTAL: entry_total_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign dim_used = (dimension_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : dimension_q;
	assign scale_n = (POS_W'(entry_total_q) > POS_W'(MAX_ENTRIES)) ?
		11'(MAX_ENTRIES) : entry_total_q;

	srmve_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd)
	);

	srmve_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.dim(dim_used),
		.scale_n(scale_n),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

// ===== rtl/srmve_checker.sv =====
`timescale 1ns / 1ps

module srmve_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input srmve_pkg::item_t                item,
	input logic                            result_valid,
	input logic                            result_stall,
	input srmve_pkg::result_t              result,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [srmve_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [10:0]                     cfg_data
);
	import srmve_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("stalled result changed");

	a_miss_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.last)
		else $error("lookup miss not marked last");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.result_value == 32'sd0)
		else $error("lookup miss with nonzero value");

endmodule

bind sparse_row_matrix_vector_engine_unit srmve_checker u_srmve_checker (.*);

// ===== tb/sparse_row_matrix_vector_engine_unit_test.sv =====
`timescale 1ns / 1ps

module sparse_row_matrix_vector_engine_unit_test;
	import srmve_pkg::*;

	localparam int ROWS = 64;
	localparam int ENTRIES = 1024;
	localparam int STALL_LIMIT = 2000000;

	typedef struct {
		bit    drain;
		item_t it;
	} pending_t;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [10:0]          cfg_data;

	sparse_row_matrix_vector_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pending_t pending_q[$];
	result_t  expected_q[$];
	bit       failed = 0;
	bit       calm = 0;
	int       results_seen = 0;
	bit       long_hold_done = 0;
	bit       accepted_any;

	// Engine state mirrored for prediction.
	logic [9:0]         m_start[ROWS];
	logic [10:0]        m_len[ROWS];
	logic [5:0]         m_col[ENTRIES];
	logic signed [31:0] m_val[ENTRIES];
	logic signed [31:0] m_x[ROWS];
	logic signed [31:0] m_sum[ROWS];
	int                 m_dim = 1;
	int                 m_total = 0;

	// Which stores the queued stimulus has written so far.
	logic [9:0]  g_start[ROWS];
	logic [10:0] g_len[ROWS];
	bit          g_ent_ok[ENTRIES];
	bit          g_x_ok[ROWS];
	bit          g_sum_ok[ROWS];
	int          g_dim = 1;
	int          g_total = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> 16;
	endfunction

	function automatic longint saturate(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	task automatic push_result(input int idx, input longint v, input bit f, input bit l);
		result_t r;
		r.result_index = idx[5:0];
		r.result_value = v[31:0];
		r.found = f;
		r.last = l;
		expected_q.push_back(r);
	endtask

	task automatic predict_item(input item_t it);
		int     p;
		int     c;
		int     n;
		longint s;
		longint v;
		bit     f;
		case (op_t'(it.opcode))
			OP_SET_ROW: begin
				m_start[it.row_index] = it.entry_index;
				m_len[it.row_index] = it.entry_count;
			end
			OP_WRITE_ENTRY: begin
				m_col[it.entry_index] = it.column_index;
				m_val[it.entry_index] = it.operand_value;
			end
			OP_WRITE_X: begin
				m_x[it.row_index] = it.operand_value;
			end
			OP_WRITE_SUM: begin
				m_sum[it.row_index] = it.operand_value;
			end
			OP_PRODUCT: begin
				for (int r = 0; r < m_dim; r++) begin
					s = it.accumulate ? longint'(m_sum[r]) : 0;
					for (int k = 0; k < m_len[r]; k++) begin
						p = m_start[r] + k;
						if (p >= ENTRIES) break;
						c = m_col[p];
						if (c >= m_dim) continue;
						s = saturate(s + q_mul(m_val[p], m_x[c]));
					end
					m_sum[r] = s[31:0];
					push_result(r, s, 1'b1, r + 1 == m_dim);
				end
			end
			OP_TRANSPOSE: begin
				for (int r = 0; r < m_dim; r++) m_sum[r] = 0;
				for (int r = 0; r < m_dim; r++) begin
					for (int k = 0; k < m_len[r]; k++) begin
						p = m_start[r] + k;
						if (p >= ENTRIES) break;
						c = m_col[p];
						if (c >= m_dim) continue;
						s = saturate(longint'(m_sum[c]) + q_mul(m_val[p], m_x[r]));
						m_sum[c] = s[31:0];
					end
				end
				for (int r = 0; r < m_dim; r++) push_result(r, m_sum[r], 1'b1, r + 1 == m_dim);
			end
			OP_LOOKUP: begin
				v = 0;
				f = 0;
				if (it.row_index < m_dim && it.column_index < m_dim) begin
					for (int k = 0; k < m_len[it.row_index]; k++) begin
						p = m_start[it.row_index] + k;
						if (p >= ENTRIES) break;
						if (m_col[p] >= it.column_index) begin
							if (m_col[p] == it.column_index) begin
								v = m_val[p];
								f = 1;
							end
							break;
						end
					end
				end
				push_result(it.column_index, v, f, 1'b1);
			end
			default: begin
				n = m_total > ENTRIES ? ENTRIES : m_total;
				for (int k = 0; k < n; k++) begin
					s = saturate(q_mul(m_val[k], it.operand_value));
					m_val[k] = s[31:0];
				end
			end
		endcase
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			2: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			default: return $signed($urandom_range(0, 32'hff)) - 32'sh80;
		endcase
	endfunction

	function automatic item_t rand_fields(input op_t op);
		item_t it;
		it.opcode = op;
		it.row_index = $urandom_range(0, 63);
		it.column_index = $urandom_range(0, 63);
		it.entry_index = $urandom_range(0, 1023);
		it.entry_count = $urandom_range(0, 1024);
		it.operand_value = rand_value();
		it.accumulate = $urandom_range(0, 1);
		return it;
	endfunction

	task automatic queue_item(input item_t it);
		pending_t pe;
		pe.drain = 0;
		pe.it = it;
		pending_q.push_back(pe);
		case (op_t'(it.opcode))
			OP_SET_ROW: begin
				g_start[it.row_index] = it.entry_index;
				g_len[it.row_index] = it.entry_count;
			end
			OP_WRITE_ENTRY: g_ent_ok[it.entry_index] = 1;
			OP_WRITE_X: g_x_ok[it.row_index] = 1;
			OP_WRITE_SUM: g_sum_ok[it.row_index] = 1;
			OP_PRODUCT, OP_TRANSPOSE: for (int r = 0; r < g_dim; r++) g_sum_ok[r] = 1;
			default: ;
		endcase
	endtask

	task automatic fill_entry(input int p);
		item_t w;
		if (!g_ent_ok[p]) begin
			w = rand_fields(OP_WRITE_ENTRY);
			w.entry_index = p;
			queue_item(w);
		end
	endtask

	task automatic fill_row(input int r);
		int p;
		for (int k = 0; k < g_len[r]; k++) begin
			p = g_start[r] + k;
			if (p >= ENTRIES) break;
			fill_entry(p);
		end
	endtask

	// Writes whatever a read-side operation would touch that was never written.
	task automatic issue(input item_t it);
		item_t w;
		int    n;
		case (op_t'(it.opcode))
			OP_PRODUCT, OP_TRANSPOSE: begin
				for (int r = 0; r < g_dim; r++) begin
					fill_row(r);
					if (!g_x_ok[r]) begin
						w = rand_fields(OP_WRITE_X);
						w.row_index = r;
						queue_item(w);
					end
					if (it.opcode == OP_PRODUCT && it.accumulate && !g_sum_ok[r]) begin
						w = rand_fields(OP_WRITE_SUM);
						w.row_index = r;
						queue_item(w);
					end
				end
			end
			OP_LOOKUP: begin
				if (it.row_index < g_dim && it.column_index < g_dim) fill_row(it.row_index);
			end
			OP_SCALE: begin
				n = g_total > ENTRIES ? ENTRIES : g_total;
				for (int k = 0; k < n; k++) fill_entry(k);
			end
			default: ;
		endcase
		queue_item(it);
	endtask

	task automatic build_row(input int r, input int start, input int cnt);
		item_t it;
		int    c;
		it = rand_fields(OP_SET_ROW);
		it.row_index = r;
		it.entry_index = start;
		it.entry_count = cnt;
		issue(it);
		c = $urandom_range(0, 3);
		for (int k = 0; k < cnt && start + k < ENTRIES && k < 12; k++) begin
			it = rand_fields(OP_WRITE_ENTRY);
			it.entry_index = start + k;
			it.column_index = c > 63 ? 63 : c;
			issue(it);
			c = c + $urandom_range(1, 4);
		end
	endtask

	// Long rows start near the end of the entry store and run past it.
	task automatic random_item();
		item_t it;
		int    sel;
		int    cnt;
		int    start;
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			if ($urandom_range(0, 99) < 4) begin
				cnt = $urandom_range(64, 1024);
				start = $urandom_range(960, 1023);
			end else begin
				cnt = $urandom_range(0, 6);
				start = $urandom_range(0, 1023);
			end
			build_row($urandom_range(0, g_dim - 1), start, cnt);
		end else if (sel < 30) begin
			it = rand_fields(OP_SET_ROW);
			if ($urandom_range(0, 99) < 4) begin
				it.entry_index = $urandom_range(960, 1023);
			end else begin
				it.entry_count = $urandom_range(0, 6);
			end
			issue(it);
		end else if (sel < 42) begin
			issue(rand_fields(OP_WRITE_ENTRY));
		end else if (sel < 52) begin
			issue(rand_fields(OP_WRITE_X));
		end else if (sel < 58) begin
			issue(rand_fields(OP_WRITE_SUM));
		end else if (sel < 72) begin
			issue(rand_fields(OP_PRODUCT));
		end else if (sel < 80) begin
			issue(rand_fields(OP_TRANSPOSE));
		end else if (sel < 97) begin
			it = rand_fields(OP_LOOKUP);
			if ($urandom_range(0, 3) != 0) it.row_index = $urandom_range(0, g_dim - 1);
			issue(it);
		end else begin
			it = rand_fields(OP_SCALE);
			if ($urandom_range(0, 3) != 0) begin
				it.operand_value = $urandom_range(32'h8000, 32'h18000);
			end
			issue(it);
		end
	endtask

	task automatic pause_sender();
		pending_t pe;
		pe.drain = 1;
		pe.it = '0;
		pending_q.push_back(pe);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_q.size() != 0 || item_valid || expected_q.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		cfg_index <= idx;
		cfg_data <= data[10:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_DIMENSION) begin
			m_dim = data > ROWS ? ROWS : data;
			g_dim = m_dim;
		end else begin
			m_total = data;
			g_total = data;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic phase_end();
		item_t it;
		it = rand_fields(OP_SCALE);
		it.operand_value = $urandom_range(32'h8000, 32'h18000);
		issue(it);
		it = rand_fields(OP_LOOKUP);
		issue(it);
		wait_idle();
	endtask

	always @(posedge clk or negedge arst_n) begin
		int       gap;
		bit       next_valid;
		pending_t pe;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			gap = 0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_item(item);
			end
			if (!(item_valid && item_stall)) begin
				next_valid = 0;
				if (gap > 0) begin
					gap--;
				end else if (pending_q.size() != 0) begin
					if (pending_q[0].drain) begin
						if (expected_q.size() == 0) void'(pending_q.pop_front());
					end else begin
						pe = pending_q.pop_front();
						item <= pe.it;
						next_valid = 1;
						gap = calm ? 0 : $urandom_range(0, 4);
					end
				end
				item_valid <= next_valid;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int      hold;
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold = 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, result);
					failed = 1;
				end else begin
					want = expected_q.pop_front();
					if (result.result_index !== want.result_index) begin
						$display("%0t: result_index expected %0d actual %0d", $time,
							want.result_index, result.result_index);
						failed = 1;
					end
					if (result.result_value !== want.result_value) begin
						$display("%0t: result_value expected %0d actual %0d", $time,
							want.result_value, result.result_value);
						failed = 1;
					end
					if (result.found !== want.found) begin
						$display("%0t: found expected %0b actual %0b", $time,
							want.found, result.found);
						failed = 1;
					end
					if (result.last !== want.last) begin
						$display("%0t: last expected %0b actual %0b", $time,
							want.last, result.last);
						failed = 1;
					end
				end
				hold = calm ? 0 : $urandom_range(0, 4);
				if (!long_hold_done && results_seen >= 20) begin
					hold = 400;
					long_hold_done = 1;
				end
			end else if (hold > 0) begin
				hold--;
			end
			result_stall <= hold > 0;
		end
	end

	always @(posedge clk) begin
		int idle_cycles;
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		item_t it;
		int    dims[5];
		int    totals[5];
		dims = '{8, 1, 64, 27, 37};
		totals = '{0, 12, 64, 30, 5};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int r = 0; r < ROWS; r++) begin
			m_start[r] = 0;
			m_len[r] = 0;
			g_start[r] = 0;
			g_len[r] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			calm = ph == 3;
			write_reg(REG_DIMENSION, dims[ph]);
			write_reg(REG_ENTRY_TOTAL, totals[ph]);
			if (ph == 0) begin
				it = rand_fields(OP_WRITE_X);
				it.row_index = 0;
				it.operand_value = 32'sh7fffffff;
				issue(it);
				it.row_index = 1;
				it.operand_value = 32'sh80000000;
				issue(it);
				build_row(0, 0, 3);
				it = rand_fields(OP_WRITE_ENTRY);
				it.entry_index = 0;
				it.column_index = 0;
				it.operand_value = 32'sh7fffffff;
				issue(it);
				it.entry_index = 1;
				it.column_index = 1;
				it.operand_value = 32'sh7fffffff;
				issue(it);
				it.entry_index = 1023;
				it.column_index = 63;
				it.operand_value = 32'sh80000000;
				issue(it);
				build_row(1, 1020, 1024);
				build_row(7, 1023, 0);
				it = rand_fields(OP_PRODUCT);
				it.accumulate = 0;
				issue(it);
				it.accumulate = 1;
				issue(it);
				issue(rand_fields(OP_TRANSPOSE));
				it = rand_fields(OP_LOOKUP);
				it.row_index = 0;
				it.column_index = 1;
				issue(it);
				it.column_index = 63;
				issue(it);
				it.row_index = 63;
				it.column_index = 0;
				issue(it);
				it.row_index = 1;
				it.column_index = 5;
				issue(it);
				it = rand_fields(OP_SCALE);
				it.operand_value = 32'shffff0000;
				issue(it);
				it.operand_value = 32'sh7fffffff;
				issue(it);
			end
			for (int n = 0; n < 10; n++) begin
				random_item();
				if (ph == 2 && n == 5) pause_sender();
			end
			phase_end();
		end

		if (!failed && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sparse_row_matrix_vector_engine_unit.f =====
rtl/srmve_pkg.sv
rtl/srmve_front.sv
rtl/srmve_back.sv
rtl/sparse_row_matrix_vector_engine_unit.sv
rtl/srmve_checker.sv
tb/sparse_row_matrix_vector_engine_unit_test.sv
